[sv/wam_pkg.sv]
// Package for the weekly alarm matcher: mode codes, transfer payload structs,
// the token that walks the cell chain, and the gesture lookup.
// No dependencies.
package wam_pkg;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] DIFF_LOW    = 2'd0;
  localparam logic [1:0] DIFF_MEDIUM = 2'd1;
  localparam logic [1:0] DIFF_HIGH   = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        alarm_enabled;
    logic [1:0]  alarm_difficulty;
    logic [15:0] entry_id;
  } in_data_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic [15:0] fired_id;
    logic [1:0]  fired_difficulty;
    logic [3:0]  gesture_count;
    logic        accepted;
    logic [4:0]  entry_total;
  } out_data_t;

  typedef struct packed {
    logic        active;
    in_data_t    item;
    logic        found;
    logic [3:0]  slot;
    logic [15:0] fid;
    logic [1:0]  fdiff;
  } token_t;

  function automatic logic [2:0] gestures_for(input logic [1:0] diff);
    logic [2:0] n;
    case (diff)
      DIFF_LOW:    n = 3'd3;
      DIFF_MEDIUM: n = 3'd5;
      DIFF_HIGH:   n = 3'd7;
      default:     n = 3'd3;
    endcase
    return n;
  endfunction

endpackage

[sv/weekly_alarm_matcher.sv]
// Top level of the weekly alarm matcher: input register, chain of wam_cell
// slots, entry count and result register. Depends on wam_pkg and wam_cell.
//
// Usage: present an item on in_data and raise start while busy is low; the
// transfer happens at that clock edge and busy rises the next cycle. Mode 0
// is a time tick, mode 1 appends an alarm entry, mode 2 empties the table.
// The item travels as a token through MAX_ENTRIES cells, one cell per
// cycle, so the first matching slot in table order claims the tick.
// Exactly one result follows each item: out_valid is high for one cycle
// with out_data, after the item has passed the input register, the cell
// chain and the result register. busy falls at the edge that ends the
// result cycle, so the next item can be accepted only after the previous
// item's result. The receiver cannot stall, so the result is simply
// dropped onto the ports for that cycle. Reset empties the table, clears
// every fired record and drops any item in flight; no result appears
// for it.
module weekly_alarm_matcher import wam_pkg::*; #(
  parameter int MAX_ENTRIES  = 16,
  parameter int MAX_GESTURES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_data_t  in_data,
  output logic      out_valid,
  output out_data_t out_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
  localparam logic [4:0] GEST_CAP = 5'(MAX_GESTURES);

  token_t           tok [0:MAX_ENTRIES];
  token_t           tok0_r;
  logic             busy_r;
  logic             out_valid_r;
  out_data_t        out_data_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             accept;
  logic             room;
  out_data_t        res_nxt;
  token_t           last;
  logic [2:0]       gest;

  assign accept = start && !busy_r;
  assign tok[0] = tok0_r;
  assign last   = tok[MAX_ENTRIES];
  assign room   = count_r < CNT_MAX;
  assign gest   = gestures_for(last.fdiff);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    wam_cell #(
      .SLOT  (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    res_nxt   = '0;
    case (last.item.mode)
      MODE_APPEND: begin
        if (room) begin
          count_nxt        = count_r + CNT_W'(1);
          res_nxt.accepted = 1'b1;
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    if (last.item.mode == MODE_TICK && last.found) begin
      res_nxt.fired            = 1'b1;
      res_nxt.fired_slot       = last.slot;
      res_nxt.fired_id         = last.fid;
      res_nxt.fired_difficulty = last.fdiff;
      res_nxt.gesture_count    = ({2'b00, gest} > GEST_CAP) ? 4'(GEST_CAP) : {1'b0, gest};
    end
    res_nxt.entry_total = 5'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.active <= 1'b0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      count_r       <= '0;
    end else begin
      tok0_r.active <= accept;
      out_valid_r   <= last.active;
      if (accept) begin
        tok0_r.item  <= in_data;
        tok0_r.found <= 1'b0;
        tok0_r.slot  <= '0;
        tok0_r.fid   <= '0;
        tok0_r.fdiff <= '0;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (out_valid_r) begin
        busy_r <= 1'b0;
      end
      if (last.active) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.active) begin
      out_data_r <= res_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/wam_cell.sv]
// One table slot of the weekly alarm matcher: the alarm entry, its fired
// record, and one stage of the token chain. Depends on wam_pkg.
module wam_cell import wam_pkg::*; #(
  parameter int SLOT  = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] count,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic        en_r;
  logic [2:0]  wd_r;
  logic [4:0]  hr_r;
  logic [5:0]  mn_r;
  logic [1:0]  diff_r;
  logic [15:0] id_r;
  logic        rec_valid_r;
  logic [8:0]  rec_day_r;
  logic [4:0]  rec_hr_r;
  logic [5:0]  rec_mn_r;
  token_t      tok_r;
  token_t      tok_nxt;
  logic        in_use;
  logic        hit;
  logic        do_fire;
  logic        do_append;

  assign in_use    = CNT_W'(SLOT) < count;
  assign hit       = en_r && (wd_r == tok_in.item.weekday) && (hr_r == tok_in.item.hour) &&
                     (mn_r == tok_in.item.minute) &&
                     !(rec_valid_r && (rec_day_r == tok_in.item.day_of_year) &&
                       (rec_hr_r == tok_in.item.hour) && (rec_mn_r == tok_in.item.minute));
  assign do_fire   = tok_in.active && (tok_in.item.mode == MODE_TICK) && !tok_in.found &&
                     in_use && hit;
  assign do_append = tok_in.active && (tok_in.item.mode == MODE_APPEND) &&
                     (CNT_W'(SLOT) == count);

  always_comb begin
    tok_nxt = tok_in;
    if (do_fire) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = 4'(SLOT);
      tok_nxt.fid   = id_r;
      tok_nxt.fdiff = diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
      rec_valid_r  <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (do_append) begin
        rec_valid_r <= 1'b0;
      end else if (do_fire) begin
        rec_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      en_r   <= tok_in.item.alarm_enabled;
      wd_r   <= tok_in.item.weekday;
      hr_r   <= tok_in.item.hour;
      mn_r   <= tok_in.item.minute;
      diff_r <= tok_in.item.alarm_difficulty;
      id_r   <= tok_in.item.entry_id;
    end
    if (do_fire) begin
      rec_day_r <= tok_in.item.day_of_year;
      rec_hr_r  <= tok_in.item.hour;
      rec_mn_r  <= tok_in.item.minute;
    end
  end

  assign tok_out = tok_r;

endmodule

[sv/wam_checker.sv]
// Port-level checks for the weekly alarm matcher, bound to its top level.
// Depends on wam_pkg and weekly_alarm_matcher.
module wam_checker import wam_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_data_t out_data
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("A result appeared while the block was not busy.");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("The block did not go busy after an input transfer.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("The result strobe stayed high for more than one cycle.");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.fired) |-> (out_data.fired_slot == 4'd0 &&
      out_data.fired_id == 16'd0 && out_data.gesture_count == 4'd0))
    else $error("Fire fields were not zero on a result without a firing.");

  a_fire_or_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.fired && out_data.accepted))
    else $error("A result reported both a firing and a stored append.");

endmodule

bind weekly_alarm_matcher wam_checker u_wam_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
